>>> sv/bss_pkg.sv
// Shared constants, register codes and config bundle for the byte signature scanner.
`default_nettype none
package bss_pkg;

  localparam int WINDOW_BYTES  = 64;
  localparam int PATTERN_BYTES = 8;
  localparam int POSITION_BITS = 48;

  localparam int BYTE_W     = 8;
  localparam int REG_W      = 64;
  localparam int LEN_W      = 4;
  localparam int OFF_W      = 6;
  localparam int WORD_BYTES = 4;
  localparam int WORD_W     = WORD_BYTES * BYTE_W;
  localparam int MATCH_W    = 48;
  localparam int CFG_IDX_W  = 4;

  localparam int OFF_MAX = (1 << OFF_W) - 1;
  localparam int SPAN_W  = $clog2(OFF_MAX + PATTERN_BYTES + WORD_BYTES + 1);
  localparam int POS_W   = $clog2(WINDOW_BYTES);
  localparam int CMP_W   = $clog2(WINDOW_BYTES + OFF_MAX + PATTERN_BYTES + WORD_BYTES) + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_PATTERN    = 4'd0,
    REG_SCAN_LENGTH     = 4'd1,
    REG_SCAN_OFFSET     = 4'd2,
    REG_CHECK_PATTERN   = 4'd3,
    REG_CHECK_LENGTH    = 4'd4,
    REG_CHECK_OFFSET    = 4'd5,
    REG_WORD_MASK_VALUE = 4'd6,
    REG_WORD_OFFSET     = 4'd7
  } cfg_reg_e;

  // Normalized configuration as seen by the match logic
  typedef struct packed {
    logic [REG_W-1:0]  scan_pattern;
    logic [LEN_W-1:0]  scan_len;
    logic [OFF_W-1:0]  scan_off;
    logic [REG_W-1:0]  check_pattern;
    logic [LEN_W-1:0]  check_len;
    logic [OFF_W-1:0]  check_off;
    logic [WORD_W-1:0] word_mask;
    logic [WORD_W-1:0] word_value;
    logic [OFF_W-1:0]  word_off;
    logic [SPAN_W-1:0] span;
    logic              span_ok;
  } cfg_t;

endpackage
`default_nettype wire

>>> sv/bss_if.sv
// Valid/ready channel interfaces for stream bytes and match results.
`default_nettype none
interface bss_byte_if;
  logic                      valid;
  logic                      ready;
  logic [bss_pkg::BYTE_W-1:0] data_byte;
  logic                      stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

interface bss_match_if;
  logic                       valid;
  logic                       ready;
  logic [bss_pkg::MATCH_W-1:0] match_start;

  modport source (output valid, output match_start, input ready);
  modport sink   (input valid, input match_start, output ready);
endinterface
`default_nettype wire

>>> sv/byte_signature_scanner.sv
// An accepted byte is held in the input register; its match result then loads the result register.
// Throughput: one byte per cycle while no held result stalls the input; set by the shift-and
// update of the candidate vector (one bit per possible start inside the window).
// Reset clears the candidate vector, byte counter, pipeline valids and config registers
// (scan length to one, all others to zero); no clearing pass is needed.
`default_nettype none
module byte_signature_scanner (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bss_pkg::REG_W-1:0]     cfg_wdata_i,
  bss_byte_if.sink                           byte_i,
  bss_match_if.source                        match_o
);
  import bss_pkg::*;

  cfg_t cfg;

  logic                     s1_valid_q;
  logic [BYTE_W-1:0]        s1_byte_q;
  logic                     s1_start_q;
  logic                     s1_adv;
  logic                     in_ready;

  logic [WINDOW_BYTES-1:0]  cand_q, cand_prev, cand_d, pos_ok;
  logic [POSITION_BITS-1:0] count_q, pos_cur;
  logic [POS_W-1:0]         hit_idx;
  logic                     match_hit;

  logic                     out_valid_q;
  logic [MATCH_W-1:0]       match_start_q;

  bss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bss_pos_match u_pos_match (
    .cfg_i       (cfg),
    .data_byte_i (s1_byte_q),
    .pos_ok_o    (pos_ok)
  );

  assign s1_adv   = s1_valid_q && (!out_valid_q || match_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign byte_i.ready = in_ready;

  // Drop all pending candidates on restart; a new candidate opens at every byte
  assign cand_prev = s1_start_q ? '0 : cand_q;
  assign cand_d    = {cand_prev[WINDOW_BYTES-2:0], 1'b1} & pos_ok;
  assign pos_cur   = s1_start_q ? '0 : count_q;
  assign hit_idx   = POS_W'(cfg.span - SPAN_W'(1));
  assign match_hit = cfg.span_ok && cand_d[hit_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && in_ready) begin
      s1_byte_q  <= byte_i.data_byte;
      s1_start_q <= byte_i.stream_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q  <= '0;
      count_q <= '0;
    end else if (s1_adv) begin
      cand_q  <= cand_d;
      count_q <= pos_cur + POSITION_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= match_hit;
    end else if (match_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && match_hit) begin
      match_start_q <= MATCH_W'(pos_cur - POSITION_BITS'(hit_idx));
    end
  end

  assign match_o.valid       = out_valid_q;
  assign match_o.match_start = match_start_q;

  // A new result only follows a byte leaving the input register
  a_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result raised without a byte in the input register");

  // The restart byte alone cannot complete a candidate longer than one byte
  a_restart_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_start_q && cfg.span > SPAN_W'(1)) |-> !match_hit)
    else $error("match reported on restart byte with multi-byte span");

  // Offset count restarts at the flagged byte
  a_restart_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_start_q) |=> (count_q == POSITION_BITS'(1)))
    else $error("byte offset did not restart");

  // An empty result register never stalls the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> byte_i.ready)
    else $error("input stalled while result register is empty");

endmodule
`default_nettype wire

>>> sv/bss_cfg.sv
// Configuration register file with length saturation and span computation.
`default_nettype none
module bss_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bss_pkg::REG_W-1:0]     cfg_wdata_i,
  output bss_pkg::cfg_t                      cfg_o
);
  import bss_pkg::*;

  logic [REG_W-1:0] scan_pattern_q, check_pattern_q, word_mask_value_q;
  logic [LEN_W-1:0] scan_length_q, check_length_q;
  logic [OFF_W-1:0] scan_offset_q, check_offset_q, word_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_pattern_q    <= '0;
      scan_length_q     <= LEN_W'(1);
      scan_offset_q     <= '0;
      check_pattern_q   <= '0;
      check_length_q    <= '0;
      check_offset_q    <= '0;
      word_mask_value_q <= '0;
      word_offset_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SCAN_PATTERN:    scan_pattern_q    <= cfg_wdata_i;
        REG_SCAN_LENGTH:     scan_length_q     <= cfg_wdata_i[LEN_W-1:0];
        REG_SCAN_OFFSET:     scan_offset_q     <= cfg_wdata_i[OFF_W-1:0];
        REG_CHECK_PATTERN:   check_pattern_q   <= cfg_wdata_i;
        REG_CHECK_LENGTH:    check_length_q    <= cfg_wdata_i[LEN_W-1:0];
        REG_CHECK_OFFSET:    check_offset_q    <= cfg_wdata_i[OFF_W-1:0];
        REG_WORD_MASK_VALUE: word_mask_value_q <= cfg_wdata_i;
        REG_WORD_OFFSET:     word_offset_q     <= cfg_wdata_i[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [LEN_W-1:0]  slen, clen;
    logic [SPAN_W-1:0] s_end, c_end, w_end, span;
    logic [WORD_W-1:0] mask;

    slen = scan_length_q;
    if (slen == '0) slen = LEN_W'(1);
    if (int'(slen) > PATTERN_BYTES) slen = LEN_W'(PATTERN_BYTES);
    clen = check_length_q;
    if (int'(clen) > PATTERN_BYTES) clen = LEN_W'(PATTERN_BYTES);
    mask = word_mask_value_q[REG_W-1:WORD_W];

    s_end = SPAN_W'(scan_offset_q) + SPAN_W'(slen);
    c_end = SPAN_W'(check_offset_q) + SPAN_W'(clen);
    w_end = SPAN_W'(word_offset_q) + SPAN_W'(WORD_BYTES);
    span  = s_end;
    if (clen != '0 && c_end > span) span = c_end;
    if (mask != '0 && w_end > span) span = w_end;

    cfg_o.scan_pattern  = scan_pattern_q;
    cfg_o.scan_len      = slen;
    cfg_o.scan_off      = scan_offset_q;
    cfg_o.check_pattern = check_pattern_q;
    cfg_o.check_len     = clen;
    cfg_o.check_off     = check_offset_q;
    cfg_o.word_mask     = mask;
    cfg_o.word_value    = word_mask_value_q[WORD_W-1:0];
    cfg_o.word_off      = word_offset_q;
    cfg_o.span          = span;
    cfg_o.span_ok       = (int'(span) <= WINDOW_BYTES);
  end

endmodule
`default_nettype wire

>>> sv/bss_pos_match.sv
// Per-position byte compare: does the new byte fit position p of a candidate.
`default_nettype none
module bss_pos_match (
  input  bss_pkg::cfg_t                         cfg_i,
  input  wire logic [bss_pkg::BYTE_W-1:0]       data_byte_i,
  output logic [bss_pkg::WINDOW_BYTES-1:0]      pos_ok_o
);
  import bss_pkg::*;

  // Position p holds up to three tests: magic byte, second-string byte, word byte
  always_comb begin
    for (int p = 0; p < WINDOW_BYTES; p++) begin
      logic [CMP_W-1:0]  pp, rs, rc, rw;
      logic              in_s, in_c, in_w, ok_s, ok_c, ok_w;
      logic [2:0]        bs, bc;
      logic [1:0]        bw;
      logic [BYTE_W-1:0] es, ec, ew, mw;

      pp = CMP_W'(p);
      rs = pp - CMP_W'(cfg_i.scan_off);
      rc = pp - CMP_W'(cfg_i.check_off);
      rw = pp - CMP_W'(cfg_i.word_off);

      in_s = (pp >= CMP_W'(cfg_i.scan_off)) && (rs < CMP_W'(cfg_i.scan_len));
      in_c = (pp >= CMP_W'(cfg_i.check_off)) && (rc < CMP_W'(cfg_i.check_len));
      in_w = (pp >= CMP_W'(cfg_i.word_off)) && (rw < CMP_W'(WORD_BYTES));

      bs = rs[2:0];
      bc = rc[2:0];
      bw = rw[1:0];
      es = cfg_i.scan_pattern[{bs, 3'b000} +: BYTE_W];
      ec = cfg_i.check_pattern[{bc, 3'b000} +: BYTE_W];
      // big-endian: word byte zero is the top byte
      ew = cfg_i.word_value[{~bw, 3'b000} +: BYTE_W];
      mw = cfg_i.word_mask[{~bw, 3'b000} +: BYTE_W];

      ok_s = !in_s || (es == data_byte_i);
      ok_c = !in_c || (ec == data_byte_i);
      ok_w = !in_w || (((ew ^ data_byte_i) & mw) == '0);
      pos_ok_o[p] = ok_s && ok_c && ok_w;
    end
  end

endmodule
`default_nettype wire
